// ===== rtl/fsmvs_pkg.sv =====
// Shared types, event codes and charge constants for the fair-share scheduler.
// No dependencies; imported by the scheduler top level.
`timescale 1ns / 1ps
`default_nettype none

package fsmvs_pkg;

   localparam int DEFAULT_SLOTS = 32;

   localparam int unsigned UNIT_LOAD        = 1024;
   localparam int unsigned TOP_WEIGHT_INDEX = 10;
   localparam int unsigned WEIGHT_COUNT     = TOP_WEIGHT_INDEX + 1;
   localparam int          NICE_LOW         = -5;
   localparam int          NICE_HIGH        = 5;

   localparam int unsigned WEIGHT [WEIGHT_COUNT] = '{
      3121, 2501, 1991, 1586, 1277, 1024, 820, 655, 526, 423, 335
   };

   // per-tick vruntime charge, truncated load over weight
   localparam logic [1:0] CHARGE [WEIGHT_COUNT] = '{
      2'(UNIT_LOAD / WEIGHT[0]), 2'(UNIT_LOAD / WEIGHT[1]), 2'(UNIT_LOAD / WEIGHT[2]),
      2'(UNIT_LOAD / WEIGHT[3]), 2'(UNIT_LOAD / WEIGHT[4]), 2'(UNIT_LOAD / WEIGHT[5]),
      2'(UNIT_LOAD / WEIGHT[6]), 2'(UNIT_LOAD / WEIGHT[7]), 2'(UNIT_LOAD / WEIGHT[8]),
      2'(UNIT_LOAD / WEIGHT[9]), 2'(UNIT_LOAD / WEIGHT[10])
   };

   typedef enum logic [1:0] {
      KIND_ARRIVE   = 2'd0,
      KIND_PICK     = 2'd1,
      KIND_TICK_END = 2'd2,
      KIND_COMPLETE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [31:0] vruntime;
      logic [15:0] arrival;
      logic [3:0]  weight_index;
   } row_type;

   // clamp niceness and map it to a weight index
   function automatic logic [3:0] nice_to_index(input logic signed [5:0] nice);
      logic [3:0] idx;
      if (nice < 6'(NICE_LOW)) begin
         idx = 4'd0;
      end else if (nice > 6'(NICE_HIGH)) begin
         idx = 4'(TOP_WEIGHT_INDEX);
      end else begin
         idx = 4'(nice - 6'(NICE_LOW));
      end
      return idx;
   endfunction

   // stale indices above the top read as the top
   function automatic logic [1:0] charge_of(input logic [3:0] wi);
      logic [3:0] idx;
      idx = (wi > 4'(TOP_WEIGHT_INDEX)) ? 4'(TOP_WEIGHT_INDEX) : wi;
      return CHARGE[idx];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fair_share_min_vruntime_scheduler.sv =====
// Fair-share scheduler top level: slot memory, scan sequencer and result register.
// Depends on fsmvs_pkg for event codes, row layout and charge table.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: an event is taken at a rising edge with start high and busy
//   low. Fields req_kind, req_process_id, req_nice_value, req_event_tick.
//   Result channel: rsp_valid is high for exactly one cycle per event, with
//   rsp_selected_id, rsp_none_ready and rsp_vruntime_value alongside. The
//   receiver cannot stall; each result must be taken in its cycle.
//   Timing: pick and arrive walk the slot memory one entry a cycle through its
//   single read port; busy stays high through the scan, drain and finish states
//   and the result is registered out of the finish state. Tick end and complete
//   do one read-modify-write in the access state, with the result registered out
//   of it. A tick end, arrive or complete naming a slot beyond the table answers
//   in the next cycle without going busy. A new event may be taken in the cycle
//   the previous result is shown, so one event runs at a time.
//   Reset clears active and written bits, the running mark and the sequencer;
//   unwritten entries read as vruntime zero and no clearing pass is needed.
module fair_share_min_vruntime_scheduler #(
   parameter int SLOTS = fsmvs_pkg::DEFAULT_SLOTS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_kind,
   input  wire logic [4:0]         req_process_id,
   input  wire logic signed [5:0]  req_nice_value,
   input  wire logic [15:0]        req_event_tick,
   output logic                    rsp_valid,
   output logic [4:0]              rsp_selected_id,
   output logic                    rsp_none_ready,
   output logic [31:0]             rsp_vruntime_value
);

   import fsmvs_pkg::*;

   localparam int          SW   = $clog2(SLOTS);
   localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_ACCESS
   } state_type;

   state_type      state_ff, state_in;
   kind_type       kind_ff, kind_in;
   logic [4:0]     pid_ff, pid_in;
   logic [3:0]     wi_ff, wi_in;
   logic [15:0]    tick_ff, tick_in;

   logic [SW-1:0]  scan_addr_ff, scan_addr_in;
   logic [SW-1:0]  scan_idx_ff, scan_idx_in;
   logic           scan_vld_ff, scan_vld_in;

   logic           found_ff, found_in;
   logic [SW-1:0]  best_idx_ff, best_idx_in;
   logic [31:0]    best_vr_ff, best_vr_in;
   logic [15:0]    best_arr_ff, best_arr_in;
   logic [31:0]    run_vr_ff, run_vr_in;

   logic [SW-1:0]  running_ff, running_in;
   logic           running_valid_ff, running_valid_in;
   logic [SLOTS-1:0] active_ff, active_in;
   logic [SLOTS-1:0] written_ff, written_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [4:0]     rsp_sel_ff, rsp_sel_in;
   logic           rsp_none_ff, rsp_none_in;
   logic [31:0]    rsp_vr_ff, rsp_vr_in;

   // slot memory
   row_type        mem_array [SLOTS];
   row_type        rd_data_ff;
   logic [SW-1:0]  rd_addr;
   logic           wr_en;
   logic [SW-1:0]  wr_addr;
   row_type        wr_data;

   logic           accept;
   logic [SW-1:0]  pid_idx;
   logic           take;
   logic           keep;
   logic [31:0]    cur_vr;
   logic [32:0]    charged;

   assign accept  = start && !busy;
   assign pid_idx = SW'(pid_ff);
   assign busy    = (state_ff != ST_IDLE);
   assign rd_addr = (state_ff == ST_SCAN) ? scan_addr_ff : SW'(req_process_id);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_array[rd_addr];
   end

   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      pid_in           = pid_ff;
      wi_in            = wi_ff;
      tick_in          = tick_ff;
      scan_addr_in     = scan_addr_ff;
      scan_idx_in      = scan_addr_ff;
      scan_vld_in      = (state_ff == ST_SCAN);
      found_in         = found_ff;
      best_idx_in      = best_idx_ff;
      best_vr_in       = best_vr_ff;
      best_arr_in      = best_arr_ff;
      run_vr_in        = run_vr_ff;
      running_in       = running_ff;
      running_valid_in = running_valid_ff;
      active_in        = active_ff;
      written_in       = written_ff;
      rsp_valid_in     = 1'b0;
      rsp_sel_in       = rsp_sel_ff;
      rsp_none_in      = 1'b0;
      rsp_vr_in        = rsp_vr_ff;
      wr_en            = 1'b0;
      wr_addr          = pid_idx;
      wr_data          = rd_data_ff;
      take             = 1'b0;
      keep             = 1'b0;
      cur_vr           = written_ff[pid_idx] ? rd_data_ff.vruntime : 32'd0;
      charged          = {1'b0, cur_vr} + 33'(charge_of(rd_data_ff.weight_index));

      // fold the beat read last cycle into the running best
      if (scan_vld_ff) begin
         if (kind_ff == KIND_PICK) begin
            take = active_ff[scan_idx_ff] &&
                   (!found_ff || (rd_data_ff.vruntime < best_vr_ff) ||
                    ((rd_data_ff.vruntime == best_vr_ff) &&
                     (rd_data_ff.arrival < best_arr_ff)));
         end else begin
            take = active_ff[scan_idx_ff] && (scan_idx_ff != pid_idx) &&
                   (!found_ff || (rd_data_ff.vruntime < best_vr_ff));
         end
         if (take) begin
            found_in    = 1'b1;
            best_idx_in = scan_idx_ff;
            best_vr_in  = rd_data_ff.vruntime;
            best_arr_in = rd_data_ff.arrival;
         end
         if (scan_idx_ff == running_ff) begin
            run_vr_in = rd_data_ff.vruntime;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in      = kind_type'(req_kind);
               pid_in       = req_process_id;
               wi_in        = nice_to_index(req_nice_value);
               tick_in      = req_event_tick;
               scan_addr_in = '0;
               found_in     = 1'b0;
               if (kind_type'(req_kind) == KIND_PICK) begin
                  state_in = ST_SCAN;
               end else if (int'(req_process_id) < SLOTS) begin
                  state_in = (kind_type'(req_kind) == KIND_ARRIVE) ? ST_SCAN : ST_ACCESS;
               end else begin
                  // slot beyond the table: answer at once, change nothing
                  rsp_valid_in = 1'b1;
                  rsp_sel_in   = req_process_id;
                  rsp_vr_in    = 32'd0;
               end
            end
         end
         ST_SCAN: begin
            if (scan_addr_ff == LAST) begin
               state_in = ST_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + SW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (kind_ff == KIND_PICK) begin
               if (!found_ff) begin
                  running_valid_in = 1'b0;
                  rsp_none_in      = 1'b1;
                  rsp_sel_in       = pid_ff;
                  rsp_vr_in        = 32'd0;
               end else begin
                  // a vruntime tie with the running slot keeps it running
                  keep = running_valid_ff && active_ff[running_ff] &&
                         (run_vr_ff == best_vr_ff);
                  running_in       = keep ? running_ff : best_idx_ff;
                  running_valid_in = 1'b1;
                  rsp_sel_in       = 5'(keep ? running_ff : best_idx_ff);
                  rsp_vr_in        = keep ? run_vr_ff : best_vr_ff;
               end
            end else begin
               wr_en                = 1'b1;
               wr_data.vruntime     = found_ff ? best_vr_ff : 32'd0;
               wr_data.arrival      = tick_ff;
               wr_data.weight_index = wi_ff;
               active_in[pid_idx]   = 1'b1;
               written_in[pid_idx]  = 1'b1;
               rsp_sel_in           = pid_ff;
               rsp_vr_in            = found_ff ? best_vr_ff : 32'd0;
            end
         end
         ST_ACCESS: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_sel_in   = pid_ff;
            rsp_vr_in    = cur_vr;
            if (kind_ff == KIND_TICK_END) begin
               if (active_ff[pid_idx]) begin
                  wr_en            = 1'b1;
                  wr_data.vruntime = charged[32] ? 32'hFFFF_FFFF : charged[31:0];
                  rsp_vr_in        = wr_data.vruntime;
               end
            end else begin
               active_in[pid_idx] = 1'b0;
               running_valid_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         scan_vld_ff      <= 1'b0;
         running_ff       <= '0;
         running_valid_ff <= 1'b0;
         active_ff        <= '0;
         written_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         rsp_none_ff      <= 1'b0;
      end else begin
         state_ff         <= state_in;
         scan_vld_ff      <= scan_vld_in;
         running_ff       <= running_in;
         running_valid_ff <= running_valid_in;
         active_ff        <= active_in;
         written_ff       <= written_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_none_ff      <= rsp_none_in;
      end
      kind_ff      <= kind_in;
      pid_ff       <= pid_in;
      wi_ff        <= wi_in;
      tick_ff      <= tick_in;
      scan_addr_ff <= scan_addr_in;
      scan_idx_ff  <= scan_idx_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_vr_ff   <= best_vr_in;
      best_arr_ff  <= best_arr_in;
      run_vr_ff    <= run_vr_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_vr_ff    <= rsp_vr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_id    = rsp_sel_ff;
   assign rsp_none_ready     = rsp_none_ff;
   assign rsp_vruntime_value = rsp_vr_ff;

`ifndef SYNTH
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted event neither busy nor answered");

   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      rsp_none_ready |-> (rsp_valid && (rsp_vruntime_value == 32'd0)))
      else $error("idle report without strobe or with nonzero vruntime");

   a_running_active: assert property (@(posedge clock) disable iff (reset)
      running_valid_ff |-> active_ff[running_ff])
      else $error("running mark on an inactive slot");

   a_scan_written: assert property (@(posedge clock) disable iff (reset)
      (scan_vld_ff && active_ff[scan_idx_ff]) |-> written_ff[scan_idx_ff])
      else $error("active slot scanned before it was written");

   a_drain_follows_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (scan_vld_ff && (scan_idx_ff == LAST)))
      else $error("drain without the last scan beat");
`endif

endmodule

`default_nettype wire
